// File: rtl/stqt_pkg.sv
// ----------------------------------------------------------------------------
// stqt_pkg
// Shared types and constants for the session traffic quota tracker.
// ----------------------------------------------------------------------------
package stqt_pkg;

  // Field widths
  localparam int CNT_W        = 64;
  localparam int TIMEOUT_W    = 32;
  localparam int MS_W         = 10;
  localparam int TIMEOUT_MS_W = TIMEOUT_W + MS_W;

  // Milliseconds per second
  localparam logic [MS_W-1:0] MS_PER_SEC = MS_W'(1000);

  // Configuration port geometry: five registers at 8-byte spacing
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int REG_IDX_W  = 3;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_ACT_THRESHOLD = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IDLE_TIMEOUT  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_INPUT     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX_OUTPUT    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_MAX_TOTAL     = 3'd4;

  // Input item
  typedef struct packed {
    logic [CNT_W-1:0] input_count;
    logic [CNT_W-1:0] output_count;
    logic [CNT_W-1:0] now_ms;
  } stqt_in_t;

  // Result item
  typedef struct packed {
    logic             was_active;
    logic             quota_hit;
    logic [CNT_W-1:0] remaining_input;
    logic [CNT_W-1:0] remaining_output;
    logic [CNT_W-1:0] remaining_total;
    logic [CNT_W-1:0] idle_deadline;
  } stqt_out_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [CNT_W-1:0]        activity_threshold;
    logic [TIMEOUT_MS_W-1:0] idle_timeout_ms;
    logic [CNT_W-1:0]        max_input_bytes;
    logic [CNT_W-1:0]        max_output_bytes;
    logic [CNT_W-1:0]        max_total_bytes;
  } stqt_cfg_t;

endpackage

// File: rtl/stqt_cfg.sv
// ----------------------------------------------------------------------------
// stqt_cfg
// Configuration register file behind an APB-style port. The idle timeout is
// also kept pre-scaled to milliseconds for the datapath.
// ----------------------------------------------------------------------------
module stqt_cfg import stqt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output stqt_cfg_t             cfg_o
);

  logic [CNT_W-1:0]        threshold_r;
  logic [TIMEOUT_W-1:0]    timeout_s_r;
  logic [TIMEOUT_MS_W-1:0] timeout_ms_r;
  logic [TIMEOUT_MS_W-1:0] timeout_ms_nxt;
  logic [CNT_W-1:0]        max_in_r;
  logic [CNT_W-1:0]        max_out_r;
  logic [CNT_W-1:0]        max_total_r;
  logic [REG_IDX_W-1:0]    reg_idx;
  logic                    wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Scale seconds to milliseconds at write time
  assign timeout_ms_nxt = TIMEOUT_MS_W'(cfg_pwdata[TIMEOUT_W-1:0])
                        * TIMEOUT_MS_W'(MS_PER_SEC);

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= '0;
      timeout_s_r  <= '0;
      timeout_ms_r <= '0;
      max_in_r     <= '0;
      max_out_r    <= '0;
      max_total_r  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ACT_THRESHOLD: threshold_r <= cfg_pwdata;
        REG_IDLE_TIMEOUT: begin
          timeout_s_r  <= cfg_pwdata[TIMEOUT_W-1:0];
          timeout_ms_r <= timeout_ms_nxt;
        end
        REG_MAX_INPUT:     max_in_r    <= cfg_pwdata;
        REG_MAX_OUTPUT:    max_out_r   <= cfg_pwdata;
        REG_MAX_TOTAL:     max_total_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_ACT_THRESHOLD: cfg_prdata = threshold_r;
      REG_IDLE_TIMEOUT:  cfg_prdata = CFG_DATA_W'(timeout_s_r);
      REG_MAX_INPUT:     cfg_prdata = max_in_r;
      REG_MAX_OUTPUT:    cfg_prdata = max_out_r;
      REG_MAX_TOTAL:     cfg_prdata = max_total_r;
      default:           cfg_prdata = '0;
    endcase
  end

  assign cfg_o.activity_threshold = threshold_r;
  assign cfg_o.idle_timeout_ms    = timeout_ms_r;
  assign cfg_o.max_input_bytes    = max_in_r;
  assign cfg_o.max_output_bytes   = max_out_r;
  assign cfg_o.max_total_bytes    = max_total_r;

endmodule

// File: rtl/stqt_core.sv
// ----------------------------------------------------------------------------
// stqt_core
// Session state and per-item update: activity decision, mark and deadline
// update, quota check and remaining byte counts.
// ----------------------------------------------------------------------------
module stqt_core import stqt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire_i,
  input  stqt_in_t  item_i,
  input  stqt_cfg_t cfg_i,
  output stqt_out_t result_o
);

  logic [CNT_W-1:0] last_in_r,  last_in_nxt;
  logic [CNT_W-1:0] last_out_r, last_out_nxt;
  logic [CNT_W-1:0] mark_in_r,  mark_in_nxt;
  logic [CNT_W-1:0] mark_out_r, mark_out_nxt;
  logic [CNT_W-1:0] deadline_r, deadline_nxt;

  logic [CNT_W:0]   diff_in;
  logic [CNT_W:0]   diff_out;
  logic [CNT_W-1:0] d_in;
  logic [CNT_W-1:0] d_out;
  logic [CNT_W:0]   d_sum;
  logic [CNT_W:0]   use_sum;
  logic             active;
  logic             hit_in;
  logic             hit_out;
  logic             hit_total;

  // Deltas against the activity marks, clamped at zero
  assign diff_in  = {1'b0, item_i.input_count}  - {1'b0, mark_in_r};
  assign diff_out = {1'b0, item_i.output_count} - {1'b0, mark_out_r};
  assign d_in     = diff_in[CNT_W]  ? '0 : diff_in[CNT_W-1:0];
  assign d_out    = diff_out[CNT_W] ? '0 : diff_out[CNT_W-1:0];
  assign d_sum    = {1'b0, d_in} + {1'b0, d_out};

  // Activity: threshold on delta sum, or any growth when threshold is zero
  always_comb begin
    if (cfg_i.activity_threshold != '0) begin
      active = d_sum >= {1'b0, cfg_i.activity_threshold};
    end else begin
      active = (item_i.input_count > last_in_r) || (item_i.output_count > last_out_r);
    end
  end

  // State update
  always_comb begin
    last_in_nxt  = item_i.input_count;
    last_out_nxt = item_i.output_count;
    mark_in_nxt  = mark_in_r;
    mark_out_nxt = mark_out_r;
    deadline_nxt = deadline_r;
    if (active) begin
      mark_in_nxt  = item_i.input_count;
      mark_out_nxt = item_i.output_count;
      if (cfg_i.idle_timeout_ms != '0) begin
        deadline_nxt = item_i.now_ms + CNT_W'(cfg_i.idle_timeout_ms);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_in_r  <= '0;
      last_out_r <= '0;
      mark_in_r  <= '0;
      mark_out_r <= '0;
      deadline_r <= '0;
    end else if (fire_i) begin
      last_in_r  <= last_in_nxt;
      last_out_r <= last_out_nxt;
      mark_in_r  <= mark_in_nxt;
      mark_out_r <= mark_out_nxt;
      deadline_r <= deadline_nxt;
    end
  end

  // Quota checks; total usage is taken at full width
  assign use_sum   = {1'b0, item_i.input_count} + {1'b0, item_i.output_count};
  assign hit_in    = (cfg_i.max_input_bytes != '0)
                   && (item_i.input_count >= cfg_i.max_input_bytes);
  assign hit_out   = (cfg_i.max_output_bytes != '0)
                   && (item_i.output_count >= cfg_i.max_output_bytes);
  assign hit_total = (cfg_i.max_total_bytes != '0)
                   && (use_sum >= {1'b0, cfg_i.max_total_bytes});

  // Result fields, after the update
  always_comb begin
    result_o.was_active       = active;
    result_o.quota_hit        = hit_in || hit_out || hit_total;
    result_o.remaining_input  = hit_in ? '0
                              : cfg_i.max_input_bytes - item_i.input_count;
    result_o.remaining_output = hit_out ? '0
                              : cfg_i.max_output_bytes - item_i.output_count;
    result_o.remaining_total  = hit_total ? '0
                              : cfg_i.max_total_bytes - use_sum[CNT_W-1:0];
    if (cfg_i.max_input_bytes == '0) begin
      result_o.remaining_input = '0;
    end
    if (cfg_i.max_output_bytes == '0) begin
      result_o.remaining_output = '0;
    end
    if (cfg_i.max_total_bytes == '0) begin
      result_o.remaining_total = '0;
    end
    result_o.idle_deadline    = deadline_nxt;
  end

endmodule

// File: rtl/session_traffic_quota_tracker.sv
// ----------------------------------------------------------------------------
// session_traffic_quota_tracker
// Tracks one traffic session from samples of its byte counters: activity,
// idle deadline, quota status and remaining bytes.
// ----------------------------------------------------------------------------
//
//   channel  | ports                               | payload
//   ---------+-------------------------------------+------------------------
//   input    | in_valid, in_stall, in_item         | stqt_in_t  (counters, time)
//   result   | out_valid, out_stall, out_item      | stqt_out_t (flags, remains)
//   config   | cfg_psel/penable/pwrite/paddr/...   | 64-bit regs at 8*index
//
// One item per cycle sustained unless out_stall holds the result. An item
// sits in the input register, where the 64-bit update against the session
// state is done, and is then held in the result register.
// Synchronous active-low reset clears the session state and valid flags, not
// the payload registers. A stalled result blocks the input register only;
// in_stall rises when both registers are full and out_stall is high.
// ----------------------------------------------------------------------------
module session_traffic_quota_tracker import stqt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  stqt_in_t              in_item,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output stqt_out_t             out_item,
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  stqt_cfg_t cfg;
  stqt_out_t result;
  stqt_in_t  item_r;
  stqt_out_t out_item_r;
  logic      item_vld_r, item_vld_nxt;
  logic      out_vld_r,  out_vld_nxt;
  logic      load;
  logic      fire;

  stqt_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  stqt_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire_i   (fire),
    .item_i   (item_r),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Handshake: process the held item whenever the result register frees up
  assign fire     = item_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = item_vld_r && !fire;
  assign load     = in_valid && !in_stall;

  assign item_vld_nxt = load || (item_vld_r && !fire);
  assign out_vld_nxt  = fire || (out_vld_r && out_stall);

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Payload registers: capture input item, hold result until taken
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
    if (fire) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  // A processed item shows up as a result the next cycle
  a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_vld_r)
    else $error("processed item did not reach the result register");

  // A stalled input side always has an item waiting in the input register
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> item_vld_r)
    else $error("input register emptied while input was stalled");

  // A new result only appears after an item was processed
  a_out_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(fire))
    else $error("result appeared without a processed item");

endmodule
